>>> hdl/bba_pkg.sv
// Package for the buddy block allocator: sizes, status codes, controller states,
// datapath commands and the status struct. No dependencies.
`default_nettype none
package bba_pkg;

    localparam int MIN_ORDER_BITS = 8;
    localparam int LEVELS         = 11;
    localparam int HEADER_BYTES   = 16;

    localparam int UNITS  = 1 << LEVELS;
    localparam int IDX_W  = LEVELS;
    localparam int LINK_W = LEVELS + 1;
    localparam int ORD_W  = 4;
    localparam int REG_W  = 12;
    localparam int REQ_W  = 20;
    localparam int SIZE_W = REQ_W + 1;
    localparam int CNT_W  = 20;
    localparam int ST_W   = 2;

    localparam logic [LINK_W-1:0] NIL_LINK  = LINK_W'(UNITS);
    localparam logic [SIZE_W-1:0] MAX_BYTES = SIZE_W'(1) << (LEVELS + MIN_ORDER_BITS);

    localparam logic [ST_W-1:0] ST_OK         = 2'd0;
    localparam logic [ST_W-1:0] ST_ALLOC_FAIL = 2'd1;
    localparam logic [ST_W-1:0] ST_BAD_FREE   = 2'd2;

    typedef struct packed {
        logic [ORD_W-1:0] order;
        logic             free;
        logic             alloc;
    } t_meta;

    localparam int META_W = $bits(t_meta);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_A_CHECK, S_A_NEED, S_A_FIND, S_A_POP, S_A_SPLIT,
        S_F_CHECK, S_F_META, S_F_BUD, S_F_BUDQ, S_F_WALK, S_F_NEXT,
        S_F_UNLINK, S_F_MERGE, S_F_PUSH
    } t_state;

    typedef enum logic [4:0] {
        C_NONE, C_CLEAR, C_ACCEPT, C_A_INIT, C_A_FAIL, C_NEED, C_INC_ORD,
        C_POP_RD, C_POP, C_SPLIT, C_A_DONE, C_F_BAD, C_F_RD, C_F_META,
        C_BUD_RD, C_WALK_INIT, C_WALK, C_NEXT, C_UNLINK_RD, C_UNLINK,
        C_MERGE, C_F_DONE
    } t_cmd;

    typedef struct packed {
        logic clear_done;
        logic a_bad;
        logic need_more;
        logic ord_over;
        logic head_nil;
        logic split_more;
        logic f_oob;
        logic f_notalloc;
        logic bud_stop;
        logic bud_nomatch;
        logic walk_hit;
        logic walk_end;
    } t_stat;

    function automatic logic [REG_W-1:0] f_clamp_region(input logic [REG_W-1:0] v);
        logic [REG_W-1:0] r;
        r = v;
        if (v == '0) begin
            r = REG_W'(1);
        end else if (v > REG_W'(UNITS)) begin
            r = REG_W'(UNITS);
        end
        return r;
    endfunction

    function automatic logic [ORD_W-1:0] f_top_order(input logic [REG_W-1:0] v);
        logic [ORD_W-1:0] k;
        k = '0;
        for (int i = 0; i <= LEVELS; i++) begin
            if (v[i]) begin
                k = ORD_W'(i);
            end
        end
        return k;
    endfunction

endpackage
`default_nettype wire

>>> hdl/bba_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module bba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [0:DEPTH-1];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

>>> hdl/bba_ctrl.sv
// Controller state machine of the buddy block allocator.
// Depends on bba_pkg.
`default_nettype none
module bba_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic          i_func,
    input  wire logic          i_cfg_we,
    input  wire bba_pkg::t_stat i_stat,
    output bba_pkg::t_cmd      o_cmd,
    output logic               o_busy
);
    bba_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bba_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            bba_pkg::S_CLEAR:   if (i_stat.clear_done) n_state = bba_pkg::S_IDLE;
            bba_pkg::S_IDLE: begin
                if (i_start) n_state = i_func ? bba_pkg::S_F_CHECK : bba_pkg::S_A_CHECK;
            end
            bba_pkg::S_A_CHECK: n_state = i_stat.a_bad ? bba_pkg::S_IDLE : bba_pkg::S_A_NEED;
            bba_pkg::S_A_NEED:  if (!i_stat.need_more) n_state = bba_pkg::S_A_FIND;
            bba_pkg::S_A_FIND: begin
                if (i_stat.ord_over) n_state = bba_pkg::S_IDLE;
                else if (!i_stat.head_nil) n_state = bba_pkg::S_A_POP;
            end
            bba_pkg::S_A_POP:   n_state = bba_pkg::S_A_SPLIT;
            bba_pkg::S_A_SPLIT: if (!i_stat.split_more) n_state = bba_pkg::S_IDLE;
            bba_pkg::S_F_CHECK: n_state = i_stat.f_oob ? bba_pkg::S_IDLE : bba_pkg::S_F_META;
            bba_pkg::S_F_META:  n_state = i_stat.f_notalloc ? bba_pkg::S_IDLE : bba_pkg::S_F_BUD;
            bba_pkg::S_F_BUD:   n_state = i_stat.bud_stop ? bba_pkg::S_F_PUSH : bba_pkg::S_F_BUDQ;
            bba_pkg::S_F_BUDQ:
                n_state = i_stat.bud_nomatch ? bba_pkg::S_F_PUSH : bba_pkg::S_F_WALK;
            bba_pkg::S_F_WALK: begin
                if (i_stat.walk_hit) n_state = bba_pkg::S_F_UNLINK;
                else if (i_stat.walk_end) n_state = bba_pkg::S_F_MERGE;
                else n_state = bba_pkg::S_F_NEXT;
            end
            bba_pkg::S_F_NEXT:   n_state = bba_pkg::S_F_WALK;
            bba_pkg::S_F_UNLINK: n_state = bba_pkg::S_F_MERGE;
            bba_pkg::S_F_MERGE:  n_state = bba_pkg::S_F_BUD;
            bba_pkg::S_F_PUSH:   n_state = bba_pkg::S_IDLE;
            default:             n_state = bba_pkg::S_IDLE;
        endcase
        if (i_cfg_we) n_state = bba_pkg::S_CLEAR;
    end

    always_comb begin
        o_cmd = bba_pkg::C_NONE;
        unique case (r_state)
            bba_pkg::S_CLEAR:   o_cmd = bba_pkg::C_CLEAR;
            bba_pkg::S_IDLE:    if (i_start) o_cmd = bba_pkg::C_ACCEPT;
            bba_pkg::S_A_CHECK: o_cmd = i_stat.a_bad ? bba_pkg::C_A_FAIL : bba_pkg::C_A_INIT;
            bba_pkg::S_A_NEED:  o_cmd = bba_pkg::C_NEED;
            bba_pkg::S_A_FIND: begin
                if (i_stat.ord_over) o_cmd = bba_pkg::C_A_FAIL;
                else if (i_stat.head_nil) o_cmd = bba_pkg::C_INC_ORD;
                else o_cmd = bba_pkg::C_POP_RD;
            end
            bba_pkg::S_A_POP:   o_cmd = bba_pkg::C_POP;
            bba_pkg::S_A_SPLIT:
                o_cmd = i_stat.split_more ? bba_pkg::C_SPLIT : bba_pkg::C_A_DONE;
            bba_pkg::S_F_CHECK: o_cmd = i_stat.f_oob ? bba_pkg::C_F_BAD : bba_pkg::C_F_RD;
            bba_pkg::S_F_META:
                o_cmd = i_stat.f_notalloc ? bba_pkg::C_F_BAD : bba_pkg::C_F_META;
            bba_pkg::S_F_BUD:   if (!i_stat.bud_stop) o_cmd = bba_pkg::C_BUD_RD;
            bba_pkg::S_F_BUDQ:  if (!i_stat.bud_nomatch) o_cmd = bba_pkg::C_WALK_INIT;
            bba_pkg::S_F_WALK: begin
                if (i_stat.walk_hit) o_cmd = bba_pkg::C_UNLINK_RD;
                else if (!i_stat.walk_end) o_cmd = bba_pkg::C_WALK;
            end
            bba_pkg::S_F_NEXT:   o_cmd = bba_pkg::C_NEXT;
            bba_pkg::S_F_UNLINK: o_cmd = bba_pkg::C_UNLINK;
            bba_pkg::S_F_MERGE:  o_cmd = bba_pkg::C_MERGE;
            bba_pkg::S_F_PUSH:   o_cmd = bba_pkg::C_F_DONE;
            default:             o_cmd = bba_pkg::C_NONE;
        endcase
    end

    assign o_busy = (r_state != bba_pkg::S_IDLE);

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == bba_pkg::S_IDLE && i_start && !i_cfg_we) |=>
        (r_state == bba_pkg::S_A_CHECK || r_state == bba_pkg::S_F_CHECK))
        else $error("accepted item did not start an operation");

    a_next_after_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == bba_pkg::S_F_NEXT) |-> ($past(r_state) == bba_pkg::S_F_WALK))
        else $error("list step without walk");

    a_pop_then_split: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == bba_pkg::S_A_POP && !i_cfg_we) |=> (r_state == bba_pkg::S_A_SPLIT))
        else $error("pop not followed by split");
endmodule
`default_nettype wire

>>> hdl/bba_dp.sv
// Datapath of the buddy block allocator: list heads, unit metadata and link RAMs,
// free counter and result registers. Depends on bba_pkg and bba_ram.
`default_nettype none
module bba_dp (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_we,
    input  wire logic [bba_pkg::REG_W-1:0]   i_cfg_data,
    input  wire bba_pkg::t_cmd               i_cmd,
    input  wire logic [bba_pkg::REQ_W-1:0]   i_request_bytes,
    input  wire logic [bba_pkg::IDX_W-1:0]   i_block_index,
    output bba_pkg::t_stat                   o_stat,
    output logic                             o_strobe,
    output logic [bba_pkg::ST_W-1:0]         o_status,
    output logic [bba_pkg::IDX_W-1:0]        o_granted_index,
    output logic [bba_pkg::ORD_W-1:0]        o_granted_order,
    output logic [bba_pkg::CNT_W-1:0]        o_free_bytes
);
    localparam int IW = bba_pkg::IDX_W;
    localparam int LW = bba_pkg::LINK_W;
    localparam int OW = bba_pkg::ORD_W;

    logic [bba_pkg::REG_W-1:0]  r_region;
    logic [OW-1:0]              r_k;
    logic [LW-1:0]              r_heads [0:bba_pkg::LEVELS], n_heads [0:bba_pkg::LEVELS];
    logic [bba_pkg::CNT_W-1:0]  r_cnt, n_cnt;
    logic [IW-1:0]              r_clr, n_clr;
    logic [bba_pkg::REQ_W-1:0]  r_req, n_req;
    logic [bba_pkg::SIZE_W-1:0] r_size, n_size;
    logic [IW-1:0]              r_bidx, n_bidx, r_blk, n_blk, r_bud, n_bud;
    logic [OW-1:0]              r_ord, n_ord, r_need, n_need;
    logic [LW-1:0]              r_cur, n_cur, r_prev, n_prev, r_steps, n_steps;
    logic                       r_strobe, n_strobe;
    logic [bba_pkg::ST_W-1:0]   r_status, n_status;
    logic [IW-1:0]              r_gidx, n_gidx;
    logic [OW-1:0]              r_gord, n_gord;
    logic [bba_pkg::CNT_W-1:0]  r_fb, n_fb;

    logic [bba_pkg::REG_W-1:0]  ld_region;
    logic [OW-1:0]              ld_k;

    logic                       meta_we, link_we;
    logic [IW-1:0]              meta_waddr, meta_raddr, link_waddr, link_raddr;
    bba_pkg::t_meta             meta_wdata, meta_q;
    logic [bba_pkg::META_W-1:0] meta_q_raw;
    logic [LW-1:0]              link_wdata, link_q;

    logic [OW-1:0]              ord_lo, ord_cl;
    logic [LW-1:0]              head_cur, head_lo;
    logic [IW-1:0]              split_bud, bud_x, hi_blk, lo_blk;
    logic [bba_pkg::CNT_W-1:0]  need_bytes, ord_bytes;

    bba_ram #(.WIDTH(bba_pkg::META_W), .DEPTH(bba_pkg::UNITS)) u_meta (
        .i_clk(i_clk), .i_we(meta_we), .i_waddr(meta_waddr), .i_wdata(meta_wdata),
        .i_raddr(meta_raddr), .o_rdata(meta_q_raw)
    );

    bba_ram #(.WIDTH(LW), .DEPTH(bba_pkg::UNITS)) u_link (
        .i_clk(i_clk), .i_we(link_we), .i_waddr(link_waddr), .i_wdata(link_wdata),
        .i_raddr(link_raddr), .o_rdata(link_q)
    );

    assign meta_q    = bba_pkg::t_meta'(meta_q_raw);
    assign ld_region = !i_rst_n ? bba_pkg::REG_W'(bba_pkg::UNITS)
                                : bba_pkg::f_clamp_region(i_cfg_data);
    assign ld_k      = bba_pkg::f_top_order(ld_region);

    assign ord_lo     = r_ord - OW'(1);
    assign ord_cl     = (meta_q.order > OW'(bba_pkg::LEVELS)) ? OW'(bba_pkg::LEVELS)
                                                              : meta_q.order;
    assign head_cur   = (r_ord > OW'(bba_pkg::LEVELS)) ? bba_pkg::NIL_LINK : r_heads[r_ord];
    assign head_lo    = r_heads[ord_lo];
    assign split_bud  = r_blk + (IW'(1) << ord_lo);
    assign bud_x      = r_blk ^ (IW'(1) << r_ord);
    assign hi_blk     = (r_bud > r_blk) ? r_bud : r_blk;
    assign lo_blk     = (r_bud < r_blk) ? r_bud : r_blk;
    assign need_bytes = bba_pkg::CNT_W'(1) << (5'(r_need) + 5'(bba_pkg::MIN_ORDER_BITS));
    assign ord_bytes  = bba_pkg::CNT_W'(1) << (5'(ord_cl) + 5'(bba_pkg::MIN_ORDER_BITS));

    always_comb begin
        o_stat.clear_done  = (r_clr == IW'(bba_pkg::UNITS - 1));
        o_stat.a_bad       = (r_req == '0) || (r_size > bba_pkg::MAX_BYTES);
        o_stat.need_more   = r_size >
            (bba_pkg::SIZE_W'(1) << (5'(r_ord) + 5'(bba_pkg::MIN_ORDER_BITS)));
        o_stat.ord_over    = (r_ord > OW'(bba_pkg::LEVELS));
        o_stat.head_nil    = (head_cur == bba_pkg::NIL_LINK);
        o_stat.split_more  = (r_ord > r_need);
        o_stat.f_oob       = ({1'b0, r_blk} >= r_region);
        o_stat.f_notalloc  = !meta_q.alloc;
        o_stat.bud_stop    = (r_ord >= OW'(bba_pkg::LEVELS)) || ({1'b0, bud_x} >= r_region);
        o_stat.bud_nomatch = !meta_q.free || (meta_q.order != r_ord);
        o_stat.walk_hit    = (r_cur == {1'b0, r_bud});
        o_stat.walk_end    = r_cur[LW-1] || r_steps[LW-1];
    end

    always_comb begin
        n_heads    = r_heads;
        n_cnt      = r_cnt;
        n_clr      = r_clr;
        n_req      = r_req;
        n_size     = r_size;
        n_bidx     = r_bidx;
        n_blk      = r_blk;
        n_bud      = r_bud;
        n_ord      = r_ord;
        n_need     = r_need;
        n_cur      = r_cur;
        n_prev     = r_prev;
        n_steps    = r_steps;
        n_strobe   = 1'b0;
        n_status   = r_status;
        n_gidx     = r_gidx;
        n_gord     = r_gord;
        n_fb       = r_fb;
        meta_we    = 1'b0;
        meta_waddr = r_blk;
        meta_wdata = '0;
        meta_raddr = r_blk;
        link_we    = 1'b0;
        link_waddr = r_blk;
        link_wdata = bba_pkg::NIL_LINK;
        link_raddr = r_blk;
        case (i_cmd)
            bba_pkg::C_CLEAR: begin
                meta_we    = 1'b1;
                meta_waddr = r_clr;
                meta_wdata = (r_clr == '0) ? '{order: r_k, free: 1'b1, alloc: 1'b0} : '0;
                link_we    = 1'b1;
                link_waddr = r_clr;
                n_clr      = r_clr + IW'(1);
            end
            bba_pkg::C_ACCEPT: begin
                n_req  = i_request_bytes;
                n_size = {1'b0, i_request_bytes} + bba_pkg::SIZE_W'(bba_pkg::HEADER_BYTES);
                n_bidx = i_block_index;
                n_blk  = i_block_index;
            end
            bba_pkg::C_A_INIT:  n_ord = '0;
            bba_pkg::C_NEED: begin
                if (o_stat.need_more) n_ord = r_ord + OW'(1);
                else n_need = r_ord;
            end
            bba_pkg::C_INC_ORD: n_ord = r_ord + OW'(1);
            bba_pkg::C_POP_RD: begin
                n_blk      = head_cur[IW-1:0];
                link_raddr = head_cur[IW-1:0];
            end
            bba_pkg::C_POP: n_heads[r_ord] = link_q;
            bba_pkg::C_SPLIT: begin
                link_we         = 1'b1;
                link_waddr      = split_bud;
                link_wdata      = head_lo;
                n_heads[ord_lo] = {1'b0, split_bud};
                meta_we         = 1'b1;
                meta_waddr      = split_bud;
                meta_wdata      = '{order: ord_lo, free: 1'b1, alloc: 1'b0};
                n_ord           = ord_lo;
            end
            bba_pkg::C_A_DONE: begin
                meta_we    = 1'b1;
                meta_waddr = r_blk;
                meta_wdata = '{order: r_need, free: 1'b0, alloc: 1'b1};
                n_cnt      = r_cnt - need_bytes;
                n_strobe   = 1'b1;
                n_status   = bba_pkg::ST_OK;
                n_gidx     = r_blk;
                n_gord     = r_need;
                n_fb       = r_cnt - need_bytes;
            end
            bba_pkg::C_A_FAIL: begin
                n_strobe = 1'b1;
                n_status = bba_pkg::ST_ALLOC_FAIL;
                n_gidx   = '0;
                n_gord   = '0;
                n_fb     = r_cnt;
            end
            bba_pkg::C_F_BAD: begin
                n_strobe = 1'b1;
                n_status = bba_pkg::ST_BAD_FREE;
                n_gidx   = '0;
                n_gord   = '0;
                n_fb     = r_cnt;
            end
            bba_pkg::C_F_RD: meta_raddr = r_blk;
            bba_pkg::C_F_META: begin
                meta_we    = 1'b1;
                meta_waddr = r_blk;
                meta_wdata = '{order: meta_q.order, free: meta_q.free, alloc: 1'b0};
                n_ord      = ord_cl;
                n_need     = ord_cl;
                n_cnt      = r_cnt + ord_bytes;
            end
            bba_pkg::C_BUD_RD: begin
                n_bud      = bud_x;
                meta_raddr = bud_x;
            end
            bba_pkg::C_WALK_INIT: begin
                n_cur   = r_heads[r_ord];
                n_prev  = bba_pkg::NIL_LINK;
                n_steps = '0;
            end
            bba_pkg::C_WALK: begin
                n_prev     = r_cur;
                link_raddr = r_cur[IW-1:0];
                n_steps    = r_steps + LW'(1);
            end
            bba_pkg::C_NEXT: n_cur = link_q;
            bba_pkg::C_UNLINK_RD: link_raddr = r_bud;
            bba_pkg::C_UNLINK: begin
                if (r_prev == bba_pkg::NIL_LINK) begin
                    n_heads[r_ord] = link_q;
                end else begin
                    link_we    = 1'b1;
                    link_waddr = r_prev[IW-1:0];
                    link_wdata = link_q;
                end
            end
            bba_pkg::C_MERGE: begin
                meta_we    = 1'b1;
                meta_waddr = hi_blk;
                meta_wdata = '{order: r_ord, free: 1'b0, alloc: 1'b0};
                n_blk      = lo_blk;
                n_ord      = r_ord + OW'(1);
            end
            bba_pkg::C_F_DONE: begin
                link_we        = 1'b1;
                link_waddr     = r_blk;
                link_wdata     = r_heads[r_ord];
                n_heads[r_ord] = {1'b0, r_blk};
                meta_we        = 1'b1;
                meta_waddr     = r_blk;
                meta_wdata     = '{order: r_ord, free: 1'b1, alloc: 1'b0};
                n_strobe       = 1'b1;
                n_status       = bba_pkg::ST_OK;
                n_gidx         = r_bidx;
                n_gord         = r_need;
                n_fb           = r_cnt;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we) begin
            r_region <= ld_region;
            r_k      <= ld_k;
            r_cnt    <= bba_pkg::CNT_W'({ld_region, bba_pkg::MIN_ORDER_BITS'(0)});
            r_clr    <= '0;
            for (int i = 0; i <= bba_pkg::LEVELS; i++) begin
                r_heads[i] <= (OW'(i) == ld_k) ? '0 : bba_pkg::NIL_LINK;
            end
        end else begin
            r_cnt   <= n_cnt;
            r_clr   <= n_clr;
            r_heads <= n_heads;
        end
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= n_strobe;
        end
        r_req    <= n_req;
        r_size   <= n_size;
        r_bidx   <= n_bidx;
        r_blk    <= n_blk;
        r_bud    <= n_bud;
        r_ord    <= n_ord;
        r_need   <= n_need;
        r_cur    <= n_cur;
        r_prev   <= n_prev;
        r_steps  <= n_steps;
        r_status <= n_status;
        r_gidx   <= n_gidx;
        r_gord   <= n_gord;
        r_fb     <= n_fb;
    end

    assign o_strobe        = r_strobe;
    assign o_status        = r_status;
    assign o_granted_index = r_gidx;
    assign o_granted_order = r_gord;
    assign o_free_bytes    = r_fb;
endmodule
`default_nettype wire

>>> hdl/buddy_block_allocator_top.sv
// Top level of the buddy block allocator: controller plus datapath.
// Depends on bba_pkg, bba_ctrl, bba_dp (and bba_ram through bba_dp).
//
//   channel  | handshake               | payload
//   ---------+-------------------------+-------------------------------------------
//   command  | start / busy            | i_func, i_request_bytes, i_block_index
//   result   | o_strobe (one cycle)    | o_status, o_granted_index, o_granted_order,
//            |                         | o_free_bytes
//   config   | i_cfg_valid/o_cfg_ready | i_cfg_data (region size in units)
//
// Allocate: check, find the needed order, skip empty lists, pop, then split once per
// level down to it; a zero or oversized request fails at the check.
// Free: check the index, read and clear the alloc bit, then per merge read the buddy,
// walk its list to unlink it and merge; finally push the block. An invalid free fails
// at the index or metadata check. The metadata and link RAMs each give one
// registered read per cycle. After reset and after every configuration write a
// clearing pass sweeps both RAMs; busy stays high meanwhile.
// The result is presented in the cycle after the operation ends; no stall.
`default_nettype none
module buddy_block_allocator_top (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      start,
    output logic                           busy,
    input  wire logic                      i_func,
    input  wire logic [19:0]               i_request_bytes,
    input  wire logic [10:0]               i_block_index,
    output logic                           o_strobe,
    output logic [1:0]                     o_status,
    output logic [10:0]                    o_granted_index,
    output logic [3:0]                     o_granted_order,
    output logic [19:0]                    o_free_bytes,
    input  wire logic                      i_cfg_valid,
    output logic                           o_cfg_ready,
    input  wire logic [11:0]               i_cfg_data
);
    bba_pkg::t_cmd  cmd;
    bba_pkg::t_stat stat;
    logic           cfg_we;

    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid & o_cfg_ready;

    bba_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .i_func(i_func),
        .i_cfg_we(cfg_we), .i_stat(stat), .o_cmd(cmd), .o_busy(busy)
    );

    bba_dp u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(cfg_we), .i_cfg_data(i_cfg_data),
        .i_cmd(cmd), .i_request_bytes(i_request_bytes), .i_block_index(i_block_index),
        .o_stat(stat), .o_strobe(o_strobe), .o_status(o_status),
        .o_granted_index(o_granted_index), .o_granted_order(o_granted_order),
        .o_free_bytes(o_free_bytes)
    );
endmodule
`default_nettype wire

>>> dv/bba_checker.sv
// Checker for buddy_block_allocator_top: watches the command, config and result
// channels, predicts each result from its own allocator model and compares.
// Depends on bba_pkg.
`timescale 1ns / 1ps
module bba_checker
    import bba_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    input  wire logic        busy,
    input  wire logic        i_func,
    input  wire logic [19:0] i_request_bytes,
    input  wire logic [10:0] i_block_index,
    input  wire logic        o_strobe,
    input  wire logic [1:0]  o_status,
    input  wire logic [10:0] o_granted_index,
    input  wire logic [3:0]  o_granted_order,
    input  wire logic [19:0] o_free_bytes,
    input  wire logic        i_cfg_valid,
    input  wire logic        o_cfg_ready,
    input  wire logic [11:0] i_cfg_data,
    output int               fail_count,
    output int               pending
);

    typedef struct packed {
        logic [ST_W-1:0]  status;
        logic [IDX_W-1:0] index;
        logic [ORD_W-1:0] order;
        logic [CNT_W-1:0] free_bytes;
    } t_grant;

    t_grant           grant_q[$];
    logic [LINK_W-1:0] heads[LEVELS+1];
    logic [LINK_W-1:0] links[UNITS];
    logic [ORD_W-1:0]  orders[UNITS];
    logic              is_free[UNITS];
    logic              is_alloc[UNITS];
    logic [CNT_W-1:0]  free_cnt;
    logic [REG_W-1:0]  region;

    task automatic report(input string what, input int got, input int want);
        $display("mismatch: %s got %0d want %0d", what, got, want);
        fail_count++;
    endtask

    task automatic rebuild_lists();
        int k;
        k = LEVELS;
        for (int i = 0; i <= LEVELS; i++) heads[i] = NIL_LINK;
        for (int i = 0; i < UNITS; i++) begin
            links[i] = '0;
            orders[i] = '0;
            is_free[i] = 1'b0;
            is_alloc[i] = 1'b0;
        end
        while (k > 0 && (1 << k) > region) k--;
        links[0] = NIL_LINK;
        orders[0] = ORD_W'(k);
        is_free[0] = 1'b1;
        heads[k] = '0;
        free_cnt = CNT_W'(int'(region) << MIN_ORDER_BITS);
    endtask

    task automatic push_free(input int idx, input int o);
        links[idx] = heads[o];
        heads[o] = LINK_W'(idx);
        orders[idx] = ORD_W'(o);
        is_free[idx] = 1'b1;
    endtask

    task automatic unlink_free(input int idx, input int o);
        int prev, cur, steps;
        prev = UNITS;
        cur = heads[o];
        steps = 0;
        while (cur < UNITS && cur != idx && steps < UNITS) begin
            prev = cur;
            cur = links[cur];
            steps++;
        end
        if (cur == idx) begin
            if (prev == UNITS) heads[o] = links[idx];
            else links[prev] = links[idx];
        end
    endtask

    task automatic predict_grant(input logic fn, input logic [19:0] req, input logic [10:0] bi);
        t_grant g;
        longint sz;
        int need, cur, blk, o, bud, hi;
        g = '0;
        g.status = ST_OK;
        if (fn == 1'b0) begin
            sz = req;
            if (sz == 0) begin
                g.status = ST_ALLOC_FAIL;
            end else begin
                sz += HEADER_BYTES;
                if (sz > (longint'(1) << (LEVELS + MIN_ORDER_BITS))) begin
                    g.status = ST_ALLOC_FAIL;
                end else begin
                    need = 0;
                    while ((longint'(1) << (need + MIN_ORDER_BITS)) < sz) need++;
                    cur = need;
                    while (cur <= LEVELS && heads[cur] == NIL_LINK) cur++;
                    if (cur > LEVELS) begin
                        g.status = ST_ALLOC_FAIL;
                    end else begin
                        blk = heads[cur];
                        heads[cur] = links[blk];
                        while (cur > need) begin
                            cur--;
                            push_free(blk + (1 << cur), cur);
                        end
                        orders[blk] = ORD_W'(need);
                        is_free[blk] = 1'b0;
                        is_alloc[blk] = 1'b1;
                        free_cnt = free_cnt - CNT_W'(1 << (need + MIN_ORDER_BITS));
                        g.index = IDX_W'(blk);
                        g.order = ORD_W'(need);
                    end
                end
            end
        end else begin
            blk = bi;
            if (blk >= region || !is_alloc[blk]) begin
                g.status = ST_BAD_FREE;
            end else begin
                o = orders[blk];
                if (o > LEVELS) o = LEVELS;
                g.index = IDX_W'(blk);
                g.order = ORD_W'(o);
                is_alloc[blk] = 1'b0;
                free_cnt = free_cnt + CNT_W'(1 << (o + MIN_ORDER_BITS));
                while (o < LEVELS) begin
                    bud = blk ^ (1 << o);
                    if (bud >= region || !is_free[bud] || orders[bud] != o) break;
                    unlink_free(bud, o);
                    hi = bud > blk ? bud : blk;
                    blk = bud < blk ? bud : blk;
                    is_free[hi] = 1'b0;
                    o++;
                end
                push_free(blk, o);
            end
        end
        g.free_bytes = free_cnt;
        grant_q.push_back(g);
    endtask

    initial begin
        fail_count = 0;
        pending = 0;
        region = REG_W'(UNITS);
        rebuild_lists();
    end

    always @(posedge i_clk) begin
        t_grant w;
        if (!i_rst_n) begin
            grant_q.delete();
            region = REG_W'(UNITS);
            rebuild_lists();
        end else begin
            if (o_strobe) begin
                if (grant_q.size() == 0) begin
                    report("result with none expected, status", o_status, 0);
                end else begin
                    w = grant_q.pop_front();
                    if (o_status != w.status) report("status", o_status, w.status);
                    if (o_granted_index != w.index)
                        report("granted_index", o_granted_index, w.index);
                    if (o_granted_order != w.order)
                        report("granted_order", o_granted_order, w.order);
                    if (o_free_bytes != w.free_bytes)
                        report("free_bytes", o_free_bytes, w.free_bytes);
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                region = i_cfg_data;
                if (region == 0) region = 1;
                if (region > UNITS) region = REG_W'(UNITS);
                rebuild_lists();
            end
            if (start && !busy) predict_grant(i_func, i_request_bytes, i_block_index);
        end
        pending = grant_q.size();
    end

endmodule

>>> dv/tb.sv
// Testbench top for buddy_block_allocator_top: clock, reset, stimulus and verdict.
// Depends on bba_pkg, the block and bba_checker.
`timescale 1ns / 1ps
module tb;
    import bba_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic        i_func = 1'b0;
    logic [19:0] i_request_bytes = '0;
    logic [10:0] i_block_index = '0;
    logic        o_strobe;
    logic [1:0]  o_status;
    logic [10:0] o_granted_index;
    logic [3:0]  o_granted_order;
    logic [19:0] o_free_bytes;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [11:0] i_cfg_data = '0;
    int          fail_count, pending;

    logic        sent_func[$];
    int          live_blocks[$];
    bit          calm = 0;
    longint      cycles = 0;
    int          regions[9] = '{2048, 0, 4095, 3, 100, 1, 0, 1500, 2048};

    buddy_block_allocator_top dut (.*);
    bba_checker chk (.*);

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > 40000000) begin
            $display("buddy_block_allocator_top verification failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        logic f;
        if (i_rst_n && o_strobe && sent_func.size() != 0) begin
            f = sent_func.pop_front();
            if (f == 1'b0 && o_status == ST_OK) live_blocks.push_back(o_granted_index);
        end
    end

    task automatic issue(input logic f, input logic [19:0] r, input logic [10:0] b);
        if (!calm && $urandom_range(0, 99) < 34) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        start <= 1'b1;
        i_func <= f;
        i_request_bytes <= r;
        i_block_index <= b;
        do @(posedge i_clk); while (busy);
        sent_func.push_back(f);
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (sent_func.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_region(input logic [11:0] v);
        drain();
        live_blocks.delete();
        i_cfg_valid <= 1'b1;
        i_cfg_data <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic random_item();
        int k, p;
        logic [19:0] r;
        p = $urandom_range(0, 99);
        if (p < 6) begin
            issue(1'b1, 20'($urandom), 11'($urandom));
        end else if (p < 48 && live_blocks.size() != 0) begin
            k = $urandom_range(0, live_blocks.size() - 1);
            issue(1'b1, 20'($urandom), 11'(live_blocks[k]));
            live_blocks.delete(k);
        end else begin
            p = $urandom_range(0, 99);
            if (p < 70) r = 20'($urandom_range(1, 2000));
            else if (p < 92) r = 20'($urandom_range(1, 70000));
            else r = 20'($urandom);
            issue(1'b0, r, 11'($urandom));
        end
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        issue(1'b0, 20'd0, 11'd0);
        issue(1'b0, 20'hFFFFF, 11'h7FF);
        issue(1'b0, 20'd524272, 11'd0);
        issue(1'b1, 20'd0, 11'd0);
        issue(1'b0, 20'd524273, 11'd0);
        issue(1'b1, 20'd0, 11'd0);
        issue(1'b1, 20'd0, 11'd2047);
        issue(1'b0, 20'd1, 11'd0);
        issue(1'b0, 20'd240, 11'd0);
        issue(1'b0, 20'd241, 11'd0);
        issue(1'b0, 20'd1000, 11'd0);
        issue(1'b1, 20'd0, 11'd1);
        issue(1'b1, 20'd0, 11'd0);
        issue(1'b1, 20'd0, 11'd0);
        issue(1'b1, 20'd0, 11'd2);
        issue(1'b1, 20'd0, 11'd4);
        issue(1'b0, 20'd262128, 11'd0);
        issue(1'b0, 20'd262129, 11'd0);
        drain();
        live_blocks.delete();

        for (int ph = 0; ph < 9; ph++) begin
            if (ph == 6) write_region(12'($urandom_range(2, 2047)));
            else write_region(12'(regions[ph]));
            if (ph == 3) begin
                issue(1'b0, 20'd240, 11'd0);
                issue(1'b1, 20'd0, 11'd3);
            end
            calm = (ph == 4);
            for (int n = 0; n < 160; n++) begin
                if (n == 80 && ph == 2) drain();
                random_item();
            end
        end
        calm = 0;

        drain();
        repeat (100) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("buddy_block_allocator_top verification clean");
        end else begin
            $display("buddy_block_allocator_top verification failed");
        end
        $finish;
    end

endmodule

>>> sim.f
hdl/bba_pkg.sv
hdl/bba_ram.sv
hdl/bba_ctrl.sv
hdl/bba_dp.sv
hdl/buddy_block_allocator_top.sv
dv/bba_checker.sv
dv/tb.sv
